/* sv/alt_pkg.sv */
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types and constants of the assembly line tokenizer.
// ----------------------------------------------------------------------------
package alt_pkg;

  localparam int unsigned MaxFields   = 4;
  localparam int unsigned BufferBytes = 4096;

  localparam int unsigned PosW   = $clog2(BufferBytes);
  localparam int unsigned FieldW = $clog2(MaxFields + 1);

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 80;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrComma    = 2'd1,
    ErrFields   = 2'd2,
    ErrOverflow = 2'd3
  } err_e;

  // Declared from the highest bit down: store_valid ends up in bit 0
  typedef struct packed {
    logic        any_error;
    err_e        error_code;
    logic [15:0] line_slot;
    logic [15:0] source_line;
    logic [2:0]  field_count;
    logic [12:0] line_length;
    logic        line_done;
    logic [1:0]  field_slot;
    logic        field_start;
    logic [11:0] store_pos;
    logic [7:0]  store_byte;
    logic        store_valid;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

/* sv/assembly_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// assembly_line_tokenizer
// Splits assembly source bytes into zero-terminated line buffer fields.
// ----------------------------------------------------------------------------
// Usage:
//   Source bytes enter on the s_axis channel, one byte per beat. Each byte
//   gives exactly one result beat on m_axis: the line buffer write, any field
//   opening, line completion on a newline, and error flags.
//   The result of an accepted byte is registered and shows on m_axis in the
//   cycle after it is taken. One byte is taken per cycle while the receiver is
//   ready; the tokenizer state (quote, comment, escape, field and fill counters)
//   is updated in one pass of logic at the accept edge, and the result sits in a single output register.
//   A new byte is taken whenever the output register is empty or its beat
//   leaves in the same cycle, so a stalled receiver holds the result and
//   back-pressures s_axis after one beat in flight.
//   Reset clears all tokenizer state, both line counters and the sticky
//   error flag, and empties the output register.
// ----------------------------------------------------------------------------
module assembly_line_tokenizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [alt_pkg::InDataW-1:0]  s_axis_tdata_i,   // [7:0] char_byte
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [0] store_valid, [8:1] store_byte, [20:9] store_pos, [21] field_start,
  // [23:22] field_slot, [24] line_done, [37:25] line_length,
  // [40:38] field_count, [56:41] source_line, [72:57] line_slot,
  // [74:73] error_code, [75] any_error, [79:76] zero
  output logic [alt_pkg::OutDataW-1:0] m_axis_tdata_o
);

  logic                      in_comment_q, in_comment_d;
  logic                      in_string_q, in_string_d;
  logic                      quote_single_q, quote_single_d;
  logic                      escape_q, escape_d;
  logic                      in_field_q, in_field_d;
  logic [alt_pkg::PosW-1:0]  fill_pos_q, fill_pos_d;
  logic [alt_pkg::FieldW-1:0] field_num_q, field_num_d;
  logic [15:0]               line_cnt_q, line_cnt_d;
  logic [15:0]               lines_emit_q, lines_emit_d;
  logic                      err_seen_q, err_seen_d;
  logic                      out_valid_q;
  alt_pkg::result_t          res_q, res_d;

  logic                      accept;
  logic [7:0]                ch;
  logic                      room;
  logic                      opening;
  logic                      is_sep;
  logic [alt_pkg::PosW:0]    pos_inc;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign ch              = s_axis_tdata_i;
  assign pos_inc         = {1'b0, fill_pos_q} + 1'b1;
  assign room            = pos_inc < (alt_pkg::PosW+1)'(alt_pkg::BufferBytes);
  assign opening         = !in_field_q;
  assign is_sep          = ch inside {alt_pkg::ChSpace, alt_pkg::ChTab,
                                      alt_pkg::ChSemi, alt_pkg::ChComma};

  always_comb begin
    in_comment_d   = in_comment_q;
    in_string_d    = in_string_q;
    quote_single_d = quote_single_q;
    escape_d       = escape_q;
    in_field_d     = in_field_q;
    fill_pos_d     = fill_pos_q;
    field_num_d    = field_num_q;
    line_cnt_d     = line_cnt_q;
    lines_emit_d   = lines_emit_q;
    err_seen_d     = err_seen_q;

    res_d             = '0;
    res_d.store_pos   = 12'(fill_pos_q);
    res_d.error_code  = alt_pkg::ErrNone;

    if (ch != 8'h00) begin
      escape_d = 1'b0;
      if (is_sep) begin
        if (in_comment_q) begin
          // comment text: drop
        end else if (in_string_q) begin
          if (room) begin
            res_d.store_valid = 1'b1;
            res_d.store_byte  = ch;
            fill_pos_d        = pos_inc[alt_pkg::PosW-1:0];
          end else begin
            res_d.error_code = alt_pkg::ErrOverflow;
          end
        end else if (in_field_q) begin
          // close the field with a zero byte
          if (room) begin
            res_d.store_valid = 1'b1;
            fill_pos_d        = pos_inc[alt_pkg::PosW-1:0];
            in_field_d        = 1'b0;
          end else begin
            res_d.error_code = alt_pkg::ErrOverflow;
          end
        end else if (ch == alt_pkg::ChComma) begin
          res_d.error_code = alt_pkg::ErrComma;
        end else if (ch == alt_pkg::ChSemi) begin
          in_comment_d = 1'b1;
        end
      end else if (ch == alt_pkg::ChNl) begin
        if (line_cnt_q != 16'hFFFF) line_cnt_d = line_cnt_q + 16'd1;
        in_comment_d = 1'b0;
        in_field_d   = 1'b0;
        if (fill_pos_q != '0) begin
          res_d.store_valid = 1'b1;
          res_d.line_done   = 1'b1;
          res_d.line_length = 13'(pos_inc);
          res_d.field_count = 3'(field_num_q);
          res_d.line_slot   = lines_emit_q;
          if (lines_emit_q != 16'hFFFF) lines_emit_d = lines_emit_q + 16'd1;
          fill_pos_d  = '0;
          field_num_d = '0;
        end
      end else if (!in_comment_q) begin
        if (opening && field_num_q >= alt_pkg::FieldW'(alt_pkg::MaxFields)) begin
          // field beyond the limit: counts as open, byte dropped
          in_field_d       = 1'b1;
          res_d.error_code = alt_pkg::ErrFields;
        end else if (!escape_q && ch == alt_pkg::ChBslash) begin
          if (opening) begin
            in_field_d        = 1'b1;
            res_d.field_start = 1'b1;
            res_d.field_slot  = 2'(field_num_q);
            field_num_d       = field_num_q + 1'b1;
          end
          escape_d = 1'b1;
        end else if (!room) begin
          res_d.error_code = alt_pkg::ErrOverflow;
        end else begin
          if (opening) begin
            in_field_d        = 1'b1;
            res_d.field_start = 1'b1;
            res_d.field_slot  = 2'(field_num_q);
            field_num_d       = field_num_q + 1'b1;
          end
          if (!escape_q && (ch == alt_pkg::ChDquote || ch == alt_pkg::ChSquote)) begin
            if (in_string_q) begin
              // only the matching quote closes the string
              if ((ch == alt_pkg::ChSquote) == quote_single_q) begin
                in_string_d    = 1'b0;
                quote_single_d = 1'b0;
              end
            end else begin
              in_string_d    = 1'b1;
              quote_single_d = (ch == alt_pkg::ChSquote);
            end
          end
          res_d.store_valid = 1'b1;
          res_d.store_byte  = ch;
          fill_pos_d        = pos_inc[alt_pkg::PosW-1:0];
        end
      end
      if (res_d.error_code != alt_pkg::ErrNone) err_seen_d = 1'b1;
    end

    res_d.source_line = line_cnt_d;
    res_d.any_error   = err_seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q   <= 1'b0;
      in_string_q    <= 1'b0;
      quote_single_q <= 1'b0;
      escape_q       <= 1'b0;
      in_field_q     <= 1'b0;
      fill_pos_q     <= '0;
      field_num_q    <= '0;
      line_cnt_q     <= '0;
      lines_emit_q   <= '0;
      err_seen_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        in_comment_q   <= in_comment_d;
        in_string_q    <= in_string_d;
        quote_single_q <= quote_single_d;
        escape_q       <= escape_d;
        in_field_q     <= in_field_d;
        fill_pos_q     <= fill_pos_d;
        field_num_q    <= field_num_d;
        line_cnt_q     <= line_cnt_d;
        lines_emit_q   <= lines_emit_d;
        err_seen_q     <= err_seen_d;
        out_valid_q    <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(alt_pkg::OutDataW - alt_pkg::ResultW)'(0), res_q};

endmodule

/* sv/alt_checker.sv */
// ----------------------------------------------------------------------------
// alt_checker
// Port-level checks of the assembly line tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module alt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [alt_pkg::OutDataW-1:0] m_axis_tdata_o
);

  alt_pkg::result_t res;
  logic             beat;
  logic             err_beat_q;

  assign res  = alt_pkg::result_t'(m_axis_tdata_o[alt_pkg::ResultW-1:0]);
  assign beat = m_axis_tvalid_o && m_axis_tready_i;

  // remember that an error has been reported on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_beat_q <= 1'b0;
    end else if (beat && res.any_error) begin
      err_beat_q <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_line_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.line_done |->
      res.store_valid && res.store_byte == 8'h00 &&
      res.line_length == {1'b0, res.store_pos} + 13'd1)
    else $error("completed line without closing zero write");

  a_no_line_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !res.line_done |->
      res.line_length == 13'd0 && res.field_count == 3'd0 && res.line_slot == 16'd0)
    else $error("line fields set without a completed line");

  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.error_code != alt_pkg::ErrNone |-> res.any_error)
    else $error("error reported without sticky flag");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && err_beat_q |-> res.any_error)
    else $error("sticky error flag cleared");

endmodule

bind assembly_line_tokenizer alt_checker u_alt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
